// ----- rtl/sema_pkg.sv -----
// ----------------------------------------------------------------------------
// sema_pkg
// Shared constants, register codes and payload types of the sensor average
// monitor.
// ----------------------------------------------------------------------------
package sema_pkg;

	localparam int FRACTION_BITS = 8;
	localparam int ALPHA_SHIFT   = 2;

	localparam int TEMP_W    = 16;
	localparam int HUM_W     = 14;
	localparam int LIGHT_W   = 16;
	localparam int COUNT_W   = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam int TEMP_AVG_W  = TEMP_W + FRACTION_BITS;
	localparam int HUM_AVG_W   = HUM_W + FRACTION_BITS;
	localparam int LIGHT_AVG_W = LIGHT_W + FRACTION_BITS;

	localparam int IN_BITS     = TEMP_W + HUM_W + LIGHT_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = 6 + TEMP_AVG_W + HUM_AVG_W + LIGHT_AVG_W + COUNT_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEMP_LOW   = 3'd0,
		CFG_TEMP_HIGH  = 3'd1,
		CFG_HUM_LOW    = 3'd2,
		CFG_HUM_HIGH   = 3'd3,
		CFG_LIGHT_HIGH = 3'd4,
		CFG_TEMP_STEP  = 3'd5,
		CFG_HUM_STEP   = 3'd6,
		CFG_LIGHT_STEP = 3'd7
	} cfg_idx_t;

	localparam logic [TEMP_W-1:0]  RST_TEMP_LOW   = 16'd0;
	localparam logic [TEMP_W-1:0]  RST_TEMP_HIGH  = 16'd4500;
	localparam logic [HUM_W-1:0]   RST_HUM_LOW    = 14'd1000;
	localparam logic [HUM_W-1:0]   RST_HUM_HIGH   = 14'd9000;
	localparam logic [LIGHT_W-1:0] RST_LIGHT_HIGH = 16'd5000;
	localparam logic [TEMP_W-1:0]  RST_TEMP_STEP  = 16'd500;
	localparam logic [HUM_W-1:0]   RST_HUM_STEP   = 14'd2000;
	localparam logic [LIGHT_W-1:0] RST_LIGHT_STEP = 16'd1500;

	// temperature low and high limits are two's complement
	typedef struct packed {
		logic [LIGHT_W-1:0] light_step_limit;
		logic [HUM_W-1:0]   humidity_step_limit;
		logic [TEMP_W-1:0]  temp_step_limit;
		logic [LIGHT_W-1:0] light_high_limit;
		logic [HUM_W-1:0]   humidity_high_limit;
		logic [HUM_W-1:0]   humidity_low_limit;
		logic [TEMP_W-1:0]  temp_high_limit;
		logic [TEMP_W-1:0]  temp_low_limit;
	} cfg_t;

	typedef struct packed {
		logic [LIGHT_W-1:0] light;
		logic [HUM_W-1:0]   humidity;
		logic [TEMP_W-1:0]  temperature;
	} sample_t;

	typedef struct packed {
		logic [COUNT_W-1:0]     sample_total;
		logic [LIGHT_AVG_W-1:0] light_avg;
		logic [HUM_AVG_W-1:0]   hum_avg;
		logic [TEMP_AVG_W-1:0]  temp_avg;
		logic                   sensor_step;
		logic                   light_high;
		logic                   humidity_low;
		logic                   humidity_high;
		logic                   temp_low;
		logic                   temp_high;
	} result_t;

endpackage

// ----- rtl/sema_cfg.sv -----
// ----------------------------------------------------------------------------
// sema_cfg
// Limit and step threshold registers, written through the configuration port.
// ----------------------------------------------------------------------------
module sema_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [sema_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sema_pkg::CFG_W-1:0]     cfg_wdata,
	output sema_pkg::cfg_t                 cfg
);
	import sema_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_low_limit      <= RST_TEMP_LOW;
			cfg_q.temp_high_limit     <= RST_TEMP_HIGH;
			cfg_q.humidity_low_limit  <= RST_HUM_LOW;
			cfg_q.humidity_high_limit <= RST_HUM_HIGH;
			cfg_q.light_high_limit    <= RST_LIGHT_HIGH;
			cfg_q.temp_step_limit     <= RST_TEMP_STEP;
			cfg_q.humidity_step_limit <= RST_HUM_STEP;
			cfg_q.light_step_limit    <= RST_LIGHT_STEP;
		end else if (cfg_wen) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TEMP_LOW:   cfg_q.temp_low_limit      <= cfg_wdata[TEMP_W-1:0];
				CFG_TEMP_HIGH:  cfg_q.temp_high_limit     <= cfg_wdata[TEMP_W-1:0];
				CFG_HUM_LOW:    cfg_q.humidity_low_limit  <= cfg_wdata[HUM_W-1:0];
				CFG_HUM_HIGH:   cfg_q.humidity_high_limit <= cfg_wdata[HUM_W-1:0];
				CFG_LIGHT_HIGH: cfg_q.light_high_limit    <= cfg_wdata[LIGHT_W-1:0];
				CFG_TEMP_STEP:  cfg_q.temp_step_limit     <= cfg_wdata[TEMP_W-1:0];
				CFG_HUM_STEP:   cfg_q.humidity_step_limit <= cfg_wdata[HUM_W-1:0];
				CFG_LIGHT_STEP: cfg_q.light_step_limit    <= cfg_wdata[LIGHT_W-1:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/sema_channel.sv -----
// ----------------------------------------------------------------------------
// sema_channel
// One channel's moving average register, its update and its step detection.
// ----------------------------------------------------------------------------
module sema_channel #(
	parameter int SAMPLE_W = 16,
	parameter int LIMIT_W  = 16,
	parameter bit SIGNED   = 1'b0
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        load,
	input  logic                                        first,
	input  logic [SAMPLE_W-1:0]                         sample,
	input  logic [LIMIT_W-1:0]                          limit,
	output logic [SAMPLE_W+sema_pkg::FRACTION_BITS-1:0] ema_next,
	output logic                                        step_hit
);
	import sema_pkg::*;

	localparam int AVG_W  = SAMPLE_W + FRACTION_BITS;
	localparam int DIFF_W = AVG_W + 1;

	logic [AVG_W-1:0]         avg_q;
	logic [AVG_W-1:0]         sample_fx;
	logic                     sample_sign;
	logic                     avg_sign;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] diff_sh;
	logic [DIFF_W-1:0]        mag;
	logic [DIFF_W-1:0]        limit_fx;

	assign sample_fx   = AVG_W'(sample) << FRACTION_BITS;
	assign sample_sign = SIGNED & sample[SAMPLE_W-1];
	assign avg_sign    = SIGNED & avg_q[AVG_W-1];
	assign diff        = $signed({sample_sign, sample_fx}) - $signed({avg_sign, avg_q});
	assign diff_sh     = diff >>> ALPHA_SHIFT;
	assign mag         = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign limit_fx    = DIFF_W'(limit) << FRACTION_BITS;
	assign step_hit    = mag >= limit_fx;
	assign ema_next    = first ? sample_fx : avg_q + diff_sh[AVG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
		end else if (load) begin
			avg_q <= ema_next;
		end
	end

endmodule

// ----- rtl/sensor_ema_anomaly_monitor.sv -----
// ----------------------------------------------------------------------------
// sensor_ema_anomaly_monitor
// Limit flags, step detection and moving averages for three sensor channels.
// ----------------------------------------------------------------------------
// Path: input register, one pass of compare and shift-add logic, result
//   register, then the master side. Throughput: 1 sample per cycle while
//   the master side accepts results.
// Reset: limits return to their defaults, averages and sample count clear.
module sensor_ema_anomaly_monitor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [sema_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sema_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// temperature[15:0], humidity[29:16], light[45:30], zero pad
	input  logic [sema_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// temp_high[0], temp_low[1], humidity_high[2], humidity_low[3],
	// light_high[4], sensor_step[5], temp_avg[29:6],
	// hum_avg[51:30], light_avg[75:52], sample_total[107:76], zero pad
	output logic [sema_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import sema_pkg::*;

	cfg_t                   cfg;
	sample_t                sample_s1;
	logic                   valid_s1;
	result_t                result;
	result_t                result_s2;
	logic                   valid_s2;
	logic [COUNT_W-1:0]     count_q;
	logic [COUNT_W-1:0]     count_next;
	logic                   advance;
	logic                   first;
	logic                   t_hi;
	logic                   h_hi;
	logic                   t_step;
	logic                   h_step;
	logic                   l_step;
	logic [TEMP_AVG_W-1:0]  t_avg_next;
	logic [HUM_AVG_W-1:0]   h_avg_next;
	logic [LIGHT_AVG_W-1:0] l_avg_next;

	sema_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign first    = count_q == '0;

	sema_channel #(.SAMPLE_W(TEMP_W), .LIMIT_W(TEMP_W), .SIGNED(1'b1)) u_temp (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.first    (first),
		.sample   (sample_s1.temperature),
		.limit    (cfg.temp_step_limit),
		.ema_next (t_avg_next),
		.step_hit (t_step)
	);

	sema_channel #(.SAMPLE_W(HUM_W), .LIMIT_W(HUM_W), .SIGNED(1'b0)) u_hum (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.first    (first),
		.sample   (sample_s1.humidity),
		.limit    (cfg.humidity_step_limit),
		.ema_next (h_avg_next),
		.step_hit (h_step)
	);

	sema_channel #(.SAMPLE_W(LIGHT_W), .LIMIT_W(LIGHT_W), .SIGNED(1'b0)) u_light (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.first    (first),
		.sample   (sample_s1.light),
		.limit    (cfg.light_step_limit),
		.ema_next (l_avg_next),
		.step_hit (l_step)
	);

	assign t_hi       = $signed(sample_s1.temperature) > $signed(cfg.temp_high_limit);
	assign h_hi       = sample_s1.humidity > cfg.humidity_high_limit;
	assign count_next = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;

	always_comb begin
		result.temp_high     = t_hi;
		result.temp_low      = ~t_hi &
			($signed(sample_s1.temperature) < $signed(cfg.temp_low_limit));
		result.humidity_high = h_hi;
		result.humidity_low  = ~h_hi & (sample_s1.humidity < cfg.humidity_low_limit);
		result.light_high    = sample_s1.light > cfg.light_high_limit;
		result.sensor_step   = ~first & (t_step | h_step | l_step);
		result.temp_avg      = t_avg_next;
		result.hum_avg       = h_avg_next;
		result.light_avg     = l_avg_next;
		result.sample_total  = count_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			count_q  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				count_q  <= count_next;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata[IN_BITS-1:0];
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_TDATA_W'(result_s2);

endmodule

// ----- rtl/sema_checker.sv -----
// ----------------------------------------------------------------------------
// sema_checker
// Port-level checks of the sensor average monitor, bound to the top level.
// ----------------------------------------------------------------------------
module sema_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [sema_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import sema_pkg::*;

	result_t            res;
	logic               seen_q;
	logic [COUNT_W-1:0] last_count_q;

	assign res = m_tdata[OUT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			last_count_q <= '0;
		end else if (m_tvalid && m_tready) begin
			seen_q       <= 1'b1;
			last_count_q <= res.sample_total;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res.temp_high && res.temp_low) &&
			!(res.humidity_high && res.humidity_low))
		else $error("high and low flag together");

	a_first_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.sample_total == COUNT_W'(1) |-> !res.sensor_step)
		else $error("step flagged on first sample");

	a_count_seq: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && seen_q && last_count_q != COUNT_MAX
		|-> res.sample_total == last_count_q + 1'b1)
		else $error("sample count out of sequence");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind sensor_ema_anomaly_monitor sema_checker u_sema_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
